>>> hdl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg: shared types and codes of the FIFO queue with delete
// Beat payloads, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fqd_pkg;

	localparam int VALUE_W = 32;
	localparam int OCC_W   = 5;

	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_DEQUEUE = 2'd1;
	localparam logic [1:0] CMD_DELETE  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]         command;
		logic [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [VALUE_W-1:0] out_value;
		logic [OCC_W-1:0]   occupancy;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       enq_write;
		logic       head_read;
		logic       deq_pop;
		logic       scan_step;
		logic       scan_close;
		logic       set_status;
		logic [2:0] status;
		logic       load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;
		logic       val_zero;
		logic       full;
		logic       empty;
		logic       found_any;
		logic       scan_last;
		logic       out_busy;
	} dp_flag_t;

endpackage

>>> hdl/fqd_dp.sv
// ----------------------------------------------------------------------------
// fqd_dp: queue datapath
// Circular entry memory, head/tail/count, delete scan with compaction, and
// the result register.
// ----------------------------------------------------------------------------
module fqd_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fqd_pkg::req_item_t  req,
	input  fqd_pkg::dp_cmd_t    cmd,
	output fqd_pkg::dp_flag_t   flag,
	output fqd_pkg::rsp_item_t  rsp,
	output logic                rsp_valid,
	input  logic                rsp_ready
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]         mem_raddr;

	logic [1:0]            command_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] deq_value_q;
	logic [2:0]            status_q;
	logic [AW-1:0]         head_q, tail_q, scan_addr_q, hole_q;
	logic [CW-1:0]         count_q, left_q;
	logic                  found_q;
	fqd_pkg::rsp_item_t    rsp_q;
	logic                  rsp_valid_q;

	logic [AW-1:0]         head_nxt, tail_nxt, tail_prv, scan_nxt;
	logic [DATA_WIDTH-1:0] val_in;
	logic                  found_any;
	logic [fqd_pkg::VALUE_W-1:0] out_value_w;
	logic [fqd_pkg::OCC_W-1:0]   occ_w;

	// width adaptation between the fixed beat fields and the storage width
	if (DATA_WIDTH <= fqd_pkg::VALUE_W) begin : g_val_narrow
		assign val_in      = req.value[DATA_WIDTH-1:0];
		assign out_value_w = fqd_pkg::VALUE_W'(deq_value_q);
	end else begin : g_val_wide
		assign val_in      = DATA_WIDTH'(req.value);
		assign out_value_w = deq_value_q[fqd_pkg::VALUE_W-1:0];
	end

	if (CW >= fqd_pkg::OCC_W) begin : g_occ_trunc
		assign occ_w = count_q[fqd_pkg::OCC_W-1:0];
	end else begin : g_occ_ext
		assign occ_w = {{(fqd_pkg::OCC_W-CW){1'b0}}, count_q};
	end

	// circular pointer arithmetic
	always_comb begin
		head_nxt = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
		tail_nxt = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
		tail_prv = (tail_q == '0) ? AW'(QUEUE_DEPTH - 1) : tail_q - AW'(1);
		scan_nxt = (scan_addr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : scan_addr_q + AW'(1);
	end

	assign found_any = found_q | (rd_data_q == value_q);

	// memory ports: enqueue writes at the tail, the scan moves entries down
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = value_q;
		if (cmd.enq_write) begin
			mem_we = 1'b1;
		end else if (cmd.scan_step && found_q) begin
			mem_we    = 1'b1;
			mem_waddr = hole_q;
			mem_wdata = rd_data_q;
		end
		mem_raddr = cmd.scan_step ? scan_nxt : head_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= req.command;
			value_q   <= val_in;
		end
		if (cmd.capture) begin
			deq_value_q <= '0;
		end else if (cmd.deq_pop) begin
			deq_value_q <= rd_data_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.head_read) begin
			scan_addr_q <= head_q;
			left_q      <= count_q - CW'(1);
		end else if (cmd.scan_step) begin
			scan_addr_q <= scan_nxt;
			left_q      <= left_q - CW'(1);
			if (found_any) begin
				hole_q <= scan_addr_q;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= '{status: status_q, out_value: out_value_w, occupancy: occ_w};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.enq_write) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CW'(1);
			end else if (cmd.deq_pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - CW'(1);
			end else if (cmd.scan_close && found_any) begin
				tail_q  <= tail_prv;
				count_q <= count_q - CW'(1);
			end
			if (cmd.head_read) begin
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				found_q <= found_any;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign flag = '{
		command:   command_q,
		val_zero:  (value_q == '0),
		full:      (count_q == CW'(QUEUE_DEPTH)),
		empty:     (count_q == '0),
		found_any: found_any,
		scan_last: (left_q == '0),
		out_busy:  rsp_valid_q & ~rsp_ready
	};

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> hdl/fqd_ctrl.sv
// ----------------------------------------------------------------------------
// fqd_ctrl: queue controller
// Decodes each command, sequences the delete scan and hands results out.
// ----------------------------------------------------------------------------
module fqd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fqd_pkg::dp_flag_t  flag,
	output fqd_pkg::dp_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DEQ    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				cmd.status     = fqd_pkg::ST_OK;
				state_nxt      = S_FINISH;
				unique case (flag.command)
					fqd_pkg::CMD_ENQUEUE: begin
						priority if (flag.val_zero) begin
							cmd.status = fqd_pkg::ST_NULL;
						end else if (flag.full) begin
							cmd.status = fqd_pkg::ST_FULL;
						end else begin
							cmd.enq_write = 1'b1;
						end
					end
					fqd_pkg::CMD_DEQUEUE: begin
						if (flag.empty) begin
							cmd.status = fqd_pkg::ST_EMPTY;
						end else begin
							cmd.head_read = 1'b1;
							state_nxt     = S_DEQ;
						end
					end
					fqd_pkg::CMD_DELETE: begin
						priority if (flag.val_zero) begin
							cmd.status = fqd_pkg::ST_NULL;
						end else if (flag.empty) begin
							cmd.status = fqd_pkg::ST_EMPTY;
						end else begin
							cmd.head_read = 1'b1;
							state_nxt     = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_DEQ: begin
				cmd.deq_pop    = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = fqd_pkg::ST_OK;
				state_nxt      = S_FINISH;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (flag.scan_last) begin
					cmd.scan_close = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = flag.found_any ? fqd_pkg::ST_OK : fqd_pkg::ST_NOT_FOUND;
					state_nxt      = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!flag.out_busy) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> hdl/fifo_queue_with_delete.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete: bounded FIFO of nonzero words with delete by value
// Enqueue, dequeue or delete the oldest matching entry; one result per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one command beat: enqueue,
//   dequeue or delete-first-match, plus the data word. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one beat per command: status,
//   the dequeued word (zero otherwise) and the occupancy after the command.
//   Commands are handled one at a time. After acceptance a decode state
//   sends enqueue, errors and the unused code 3 on to the finish state;
//   dequeue passes through an extra state for the registered memory read;
//   delete scans the entries held, reading one entry per cycle through the
//   single read port and moving later entries down one slot in the same
//   pass. req_ready rises together with rsp_valid. If the receiver stalls,
//   a second finished result waits in the datapath, the controller holds in
//   its finish state and req_ready stays low until the output register
//   frees up. Reset clears pointers, count and both channel states; memory
//   contents are not reset since only live entries are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete #(
	parameter int QUEUE_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fqd_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output fqd_pkg::rsp_item_t rsp
);

	// command and status bundles between controller and datapath
	fqd_pkg::dp_cmd_t  dp_cmd;
	fqd_pkg::dp_flag_t dp_flag;

	// sequence each command: decode, optional read or scan, then drop the
	// result into the output register
	fqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.flag      (dp_flag),
		.cmd       (dp_cmd)
	);

	// hold entries in a circular memory; advance head on dequeue, tail on
	// enqueue, and pull tail back one slot after a successful delete
	fqd_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (dp_cmd),
		.flag      (dp_flag),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

>>> test/fqd_result_check.sv
// ----------------------------------------------------------------------------
// fqd_result_check: command tracker and result comparison for the FIFO queue
// Mirrors the queue contents from accepted command beats, predicts each
// result beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module fqd_result_check #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  fqd_pkg::req_item_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  fqd_pkg::rsp_item_t rsp,
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output int                 full_rejects,
	output int                 delete_hits,
	output int                 delete_misses,
	output int                 peak_occupancy
);

	logic [fqd_pkg::VALUE_W-1:0] held_words [QUEUE_DEPTH];
	int                          held_count;
	fqd_pkg::rsp_item_t          due_results [$];
	fqd_pkg::rsp_item_t          want;
	fqd_pkg::rsp_item_t          predicted;
	int                          n_bad;
	int                          n_checked;
	int                          n_full;
	int                          n_hit;
	int                          n_miss;
	int                          n_peak;

	// Apply one command to the mirrored queue and return the result it gives.
	function automatic fqd_pkg::rsp_item_t queue_step(fqd_pkg::req_item_t beat);
		fqd_pkg::rsp_item_t r;
		int                 pos;
		int                 i;
		r.status    = fqd_pkg::ST_OK;
		r.out_value = '0;
		pos         = -1;
		unique case (beat.command)
			fqd_pkg::CMD_ENQUEUE: begin
				if (beat.value == '0)
					r.status = fqd_pkg::ST_NULL;
				else if (held_count >= QUEUE_DEPTH)
					r.status = fqd_pkg::ST_FULL;
				else begin
					held_words[held_count] = beat.value;
					held_count++;
				end
			end
			fqd_pkg::CMD_DEQUEUE: begin
				if (held_count == 0)
					r.status = fqd_pkg::ST_EMPTY;
				else begin
					r.out_value = held_words[0];
					pos = 0;
				end
			end
			fqd_pkg::CMD_DELETE: begin
				if (beat.value == '0)
					r.status = fqd_pkg::ST_NULL;
				else if (held_count == 0)
					r.status = fqd_pkg::ST_EMPTY;
				else begin
					// scan from the tail so the oldest match wins
					for (i = held_count - 1; i >= 0; i--)
						if (held_words[i] == beat.value)
							pos = i;
					r.status = (pos >= 0) ? fqd_pkg::ST_OK : fqd_pkg::ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		if (pos >= 0) begin
			for (i = pos; i < held_count - 1; i++)
				held_words[i] = held_words[i + 1];
			held_count--;
		end
		r.occupancy = held_count[fqd_pkg::OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			due_results.delete();
			n_bad     = 0;
			n_checked = 0;
			n_full    = 0;
			n_hit     = 0;
			n_miss    = 0;
			n_peak    = 0;
		end else begin
			// results first: a result never belongs to a command of the same edge
			if (rsp_valid && rsp_ready) begin
				n_checked++;
				if (due_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"result beat %0d arrived with no command outstanding: ",
							"status %0d value %h occupancy %0d"},
							n_checked, rsp.status, rsp.out_value, rsp.occupancy);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status || rsp.out_value !== want.out_value ||
							rsp.occupancy !== want.occupancy) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"result beat %0d: expected status %0d value %h ",
								"occupancy %0d, got status %0d value %h occupancy %0d"},
								n_checked, want.status, want.out_value, want.occupancy,
								rsp.status, rsp.out_value, rsp.occupancy);
					end
				end
			end
			if (req_valid && req_ready) begin
				predicted = queue_step(req);
				due_results.push_back(predicted);
				if (predicted.status == fqd_pkg::ST_FULL)
					n_full++;
				if (req.command == fqd_pkg::CMD_DELETE && predicted.status == fqd_pkg::ST_OK)
					n_hit++;
				if (predicted.status == fqd_pkg::ST_NOT_FOUND)
					n_miss++;
				if (int'(predicted.occupancy) > n_peak)
					n_peak = int'(predicted.occupancy);
			end
		end
		fail_count     <= n_bad;
		pending        <= due_results.size();
		checked        <= n_checked;
		full_rejects   <= n_full;
		delete_hits    <= n_hit;
		delete_misses  <= n_miss;
		peak_occupancy <= n_peak;
	end

endmodule

>>> test/tb_fifo_queue_with_delete.sv
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_delete: stimulus and verdict for the FIFO queue
// Drives a directed opening, four randomized phases with different idle and
// stall mixes, and a back-pressure burst that fills the queue; the result
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_delete;

	localparam int QUEUE_DEPTH      = 16;
	localparam int LIMIT_CYCLES     = 400000;
	localparam int HOLD_CYCLES      = 300;
	localparam int DRAIN_CYCLES     = 25;
	localparam int RANDOM_PER_PHASE = 197;

	// the block ignores the fourth command code
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		PH_DIRECTED,
		PH_STEADY,
		PH_SEND_GAPS,
		PH_RECV_STALLS,
		PH_BOTH,
		PH_PRESSURE
	} phase_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	fqd_pkg::req_item_t req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	fqd_pkg::rsp_item_t rsp;

	phase_t                      phase       = PH_DIRECTED;
	bit                          hold_done   = 1'b0;
	int                          cycle_count = 0;
	logic [fqd_pkg::VALUE_W-1:0] value_pool [8];

	int fail_count;
	int pending;
	int checked;
	int full_rejects;
	int delete_hits;
	int delete_misses;
	int peak_occupancy;

	always #5 clk = ~clk;

	fifo_queue_with_delete #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH (fqd_pkg::VALUE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	fqd_result_check #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.full_rejects  (full_rejects),
		.delete_hits   (delete_hits),
		.delete_misses (delete_misses),
		.peak_occupancy(peak_occupancy)
	);

	// Percent of cycles the sender sits idle between beats in each phase.
	function automatic int idle_pct(phase_t p);
		unique case (p)
			PH_SEND_GAPS: return 56;
			PH_BOTH:      return 13;
			default:      return 0;
		endcase
	endfunction

	// Percent of cycles the receiver drops rsp_ready in each phase.
	function automatic int stall_pct(phase_t p);
		unique case (p)
			PH_RECV_STALLS: return 56;
			PH_BOTH:        return 13;
			default:        return 0;
		endcase
	endfunction

	// Mostly values from a small pool so deletes find matches and duplicates
	// pile up; a few nulls and fully random words for bit coverage.
	function automatic logic [fqd_pkg::VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return '0;
		else if (roll < 70)
			return value_pool[$urandom_range(7)];
		else
			return $urandom();
	endfunction

	// Weight enqueues by enq_pct; split the rest between dequeue and delete,
	// with a trickle of the unused code.
	function automatic fqd_pkg::req_item_t random_beat(int enq_pct);
		fqd_pkg::req_item_t beat;
		int                 roll;
		roll       = $urandom_range(99);
		beat.value = pick_value();
		if (roll < enq_pct)
			beat.command = fqd_pkg::CMD_ENQUEUE;
		else if (roll < enq_pct + (97 - enq_pct) / 2)
			beat.command = fqd_pkg::CMD_DEQUEUE;
		else if (roll < 97)
			beat.command = fqd_pkg::CMD_DELETE;
		else
			beat.command = CMD_UNUSED;
		return beat;
	endfunction

	// Offer one command beat, hold it until accepted, then idle at random.
	task automatic send_beat(input logic [1:0] cmd,
			input logic [fqd_pkg::VALUE_W-1:0] val);
		fqd_pkg::req_item_t beat;
		beat.command = cmd;
		beat.value   = val;
		req       <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		while ($urandom_range(99) < idle_pct(phase)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Run one randomized phase; alternate fill-heavy and drain-heavy stretches
	// so the occupancy swings between empty and full.
	task automatic run_phase(input phase_t p);
		fqd_pkg::req_item_t beat;
		int                 k;
		phase <= p;
		for (k = 0; k < RANDOM_PER_PHASE; k++) begin
			beat = random_beat(((k / 50) % 2 == 0) ? 65 : 25);
			send_beat(beat.command, beat.value);
		end
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Hard stop in case the block hangs.
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("timeout after %0d cycles with %0d results outstanding",
			cycle_count, pending);
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls per phase, plus one long hold-off when the
	// back-pressure phase starts so the block backs up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (phase == PH_PRESSURE && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else
				rsp_ready <= ($urandom_range(99) >= stall_pct(phase));
		end
	end

	initial begin
		int k;
		value_pool[0] = 32'hFFFF_FFFF;
		value_pool[1] = 32'h0000_0001;
		value_pool[2] = 32'h8000_0000;
		for (k = 3; k < 8; k++)
			value_pool[k] = $urandom() | 32'h1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty cases, nulls, the unused code, extremes,
		// duplicates, and deletes at head, middle and tail.
		send_beat(fqd_pkg::CMD_DEQUEUE, 32'h0);            // dequeue on empty
		send_beat(fqd_pkg::CMD_DELETE, 32'h5);             // delete on empty
		send_beat(fqd_pkg::CMD_DELETE, 32'h0);             // null delete, empty queue
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'h0);            // null enqueue
		send_beat(CMD_UNUSED, 32'hFFFF_FFFF);              // ignored code
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'h0000_0001);
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'h8000_0000);
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'h0000_0001);    // duplicate
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'hAAAA_AAAA);
		send_beat(fqd_pkg::CMD_DELETE, 32'h0000_0001);     // oldest of the duplicates
		send_beat(fqd_pkg::CMD_DELETE, 32'h0000_0007);     // no match
		send_beat(fqd_pkg::CMD_DELETE, 32'h0);             // null delete, queue busy
		send_beat(CMD_UNUSED, 32'h0);
		send_beat(fqd_pkg::CMD_DELETE, 32'hAAAA_AAAA);     // tail entry
		send_beat(fqd_pkg::CMD_ENQUEUE, 32'h5555_5555);    // tail must follow the delete
		send_beat(fqd_pkg::CMD_DEQUEUE, 32'h1234_5678);    // value ignored
		send_beat(fqd_pkg::CMD_DELETE, 32'h8000_0000);     // head entry
		send_beat(fqd_pkg::CMD_DEQUEUE, 32'h0);
		send_beat(fqd_pkg::CMD_DEQUEUE, 32'h0);
		send_beat(fqd_pkg::CMD_DEQUEUE, 32'h0);            // empty again
		send_beat(fqd_pkg::CMD_DELETE, 32'h5555_5555);     // delete on empty

		run_phase(PH_STEADY);
		run_phase(PH_SEND_GAPS);
		run_phase(PH_RECV_STALLS);
		run_phase(PH_BOTH);

		// Back-pressure: the receiver holds off while enqueues keep coming,
		// then the burst overfills the queue and drains it.
		phase <= PH_PRESSURE;
		for (k = 0; k < 42; k++) begin
			if (k < 20)
				send_beat(fqd_pkg::CMD_ENQUEUE, value_pool[k % 8] ^ (k << 8));
			else if (k < 24)
				send_beat(fqd_pkg::CMD_DELETE, value_pool[k % 8] ^ (k << 8));
			else
				send_beat(fqd_pkg::CMD_DEQUEUE, $urandom());
		end
		req_valid <= 1'b0;

		// let the checker see the last acceptance, then drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d result beats: steady, gapped, stalled, back-pressured",
			checked);
		$display("delete hits %0d, delete misses %0d, full rejects %0d, peak occupancy %0d",
			delete_hits, delete_misses, full_rejects, peak_occupancy);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else begin
			$display("%0d mismatches, %0d results outstanding", fail_count, pending);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/fqd_pkg.sv
hdl/fqd_dp.sv
hdl/fqd_ctrl.sv
hdl/fifo_queue_with_delete.sv
test/fqd_result_check.sv
test/tb_fifo_queue_with_delete.sv
